FILE: design/bfla_pkg.sv
// shared types and constants of the buffer free-list allocator
package bfla_pkg;

   // fixed field widths
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 16;
   localparam int COUNT_W   = 11;
   localparam int SPAN_W    = COUNT_W + SIZE_W;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W  = 3;
   localparam int STEP_W    = $clog2(COUNT_W);

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUF_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUF_COUNT = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd2048;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EXHAUSTED  = 3'd1,
      ST_NULL       = 3'd2,
      ST_RANGE      = 3'd3,
      ST_MISALIGNED = 3'd4,
      ST_DOUBLE     = 3'd5
   } status_type;

   // commands from the controller to the free stack
   typedef struct packed {
      logic               pop;
      logic               push;
      logic               refill;
      logic [COUNT_W-1:0] refill_count;
      logic [COUNT_W-1:0] push_idx;
   } stack_cmd_type;

endpackage

FILE: design/bfla_if.sv
// request and response channel interfaces of the buffer free-list allocator
interface bfla_req_if import bfla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, output req_type, output addr, input ready);
   modport sink (input valid, input req_type, input addr, output ready);
endinterface

interface bfla_rsp_if import bfla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   alloc_addr;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output alloc_addr, output free_count,
                   input ready);
   modport sink (input valid, input status, input alloc_addr, input free_count,
                 output ready);
endinterface

FILE: design/bfla_stack.sv
// free index stack: memory, top pointer and low-water mark
module bfla_stack import bfla_pkg::*; #(
   parameter int MAX_BUFFERS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stack_cmd_type        cmd,
   output logic [COUNT_W-1:0]   top,
   output logic [(MAX_BUFFERS > 1 ? $clog2(MAX_BUFFERS) : 1)-1:0] pop_idx
);

   localparam int IDX_W = MAX_BUFFERS > 1 ? $clog2(MAX_BUFFERS) : 1;
   localparam int CAP   = MAX_BUFFERS > 2047 ? 2047 : MAX_BUFFERS;
   localparam logic [COUNT_W-1:0] TOP_RESET =
      (COUNT_RESET > COUNT_W'(CAP)) ? COUNT_W'(CAP) : COUNT_RESET;

   logic [IDX_W-1:0]   mem [MAX_BUFFERS];
   logic [IDX_W-1:0]   rd_data_ff;
   logic [COUNT_W-1:0] top_ff, top_in;
   logic [COUNT_W-1:0] low_ff, low_in;
   logic               ident_ff;
   logic [COUNT_W-1:0] ident_val_ff;
   logic [COUNT_W-1:0] pop_ptr;

   // entries below the low-water mark are untouched since the last refill
   // and read as their own index
   assign pop_ptr = top_ff - COUNT_W'(1);

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      priority if (cmd.refill) begin
         top_in = cmd.refill_count;
         low_in = cmd.refill_count;
      end else if (cmd.pop) begin
         top_in = pop_ptr;
         if (pop_ptr < low_ff) begin
            low_in = pop_ptr;
         end
      end else if (cmd.push) begin
         top_in = top_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TOP_RESET;
         low_ff <= TOP_RESET;
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   // memory port: one read on pop, one write on push, never in the same cycle
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_data_ff   <= mem[IDX_W'(pop_ptr)];
         ident_ff     <= pop_ptr < low_ff;
         ident_val_ff <= pop_ptr;
      end
      if (cmd.push) begin
         mem[IDX_W'(top_ff)] <= IDX_W'(cmd.push_idx);
      end
   end

   assign top     = top_ff;
   assign pop_idx = ident_ff ? IDX_W'(ident_val_ff) : rd_data_ff;

endmodule

FILE: design/bfla_divider.sv
// serial divider: one quotient bit per cycle, offset by buffer size
module bfla_divider import bfla_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SPAN_W-1:0]  dividend,
   input  logic [SIZE_W-1:0]  divisor,
   output logic [COUNT_W-1:0] quotient,
   output logic               rem_zero,
   output logic               done
);

   localparam int DSH_W = SIZE_W + COUNT_W - 1;

   logic               busy_ff;
   logic               done_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [SPAN_W-1:0]  rem_ff;
   logic [DSH_W-1:0]   dsh_ff;
   logic [COUNT_W-1:0] quo_ff;
   logic               fits;

   // the dividend is below the span, so the quotient fits in COUNT_W bits
   assign fits = rem_ff >= SPAN_W'(dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // restoring step against the divisor shifted to the current bit
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend;
         dsh_ff  <= {divisor, (COUNT_W - 1)'(0)};
         quo_ff  <= '0;
         step_ff <= STEP_W'(COUNT_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - SPAN_W'(dsh_ff);
         end
         quo_ff  <= {quo_ff[COUNT_W-2:0], fits};
         dsh_ff  <= dsh_ff >> 1;
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   assign quotient = quo_ff;
   assign rem_zero = rem_ff == '0;
   assign done     = done_ff;

endmodule

FILE: design/buffer_free_list_allocator.sv
// Fixed-size buffer pool allocator. A free stack of buffer indices lives in a
// single-port synchronous memory; an allocate pops an index and returns the
// base address plus index times the buffer size, a free checks the address and
// pushes its offset from the base divided by the buffer size. One request is in
// work at a time. An allocate passes through the memory read, the multiply and
// the add, then the result register, and the next request can transfer once the
// result is loaded. A free that reaches the divider waits for the serial divider,
// which produces one of eleven quotient bits per cycle. A null or out-of-range
// free is answered from the check state and an exhausted allocate goes straight
// to the result. The result register lets a new request transfer while the
// previous result still waits; a second finished result holds the sequencer
// until the first has been taken. Writing buf_count refills the stack: a
// low-water mark makes every entry not pushed since the refill read as its own
// index, so there is no clearing pass after reset.
module buffer_free_list_allocator import bfla_pkg::*; #(
   parameter int MAX_BUFFERS = 1024,
   parameter int ADDR_BITS   = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   bfla_req_if.sink             req_chan,
   bfla_rsp_if.source           rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W  = MAX_BUFFERS > 1 ? $clog2(MAX_BUFFERS) : 1;
   localparam int PROD_W = IDX_W + SIZE_W;
   localparam int CAP    = MAX_BUFFERS > 2047 ? 2047 : MAX_BUFFERS;
   localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);
   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? '1 :
      ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_POP   = 6'b000010,
      S_ADD   = 6'b000100,
      S_CHECK = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   base_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_use;
   logic [SPAN_W-1:0]   span_ff;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   alloc_ff, alloc_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   status_type          status_ff, status_in;
   logic [ADDR_W-1:0]   offset;
   logic                rsp_load;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_alloc_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   stack_cmd_type       stack_cmd;
   logic [COUNT_W-1:0]  stack_top;
   logic [IDX_W-1:0]    pop_idx;
   logic                div_start;
   logic [COUNT_W-1:0]  div_quotient;
   logic                div_rem_zero;
   logic                div_done;

   // configuration registers and the pool span they imply
   assign count_use = (count_ff > CAP_V) ? CAP_V : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         size_ff  <= SIZE_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BASE_ADDR: base_ff  <= csr_wdata[ADDR_W-1:0];
            CSR_BUF_SIZE:  size_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_BUF_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= SPAN_W'(count_use) * SPAN_W'(size_ff);
   end

   assign offset = addr_ff - base_ff;

   // request sequencer
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      alloc_in  = alloc_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      rsp_load  = 1'b0;
      div_start = 1'b0;

      stack_cmd              = '0;
      stack_cmd.refill       = csr_write_en && (csr_index == CSR_BUF_COUNT);
      stack_cmd.refill_count = (csr_wdata[COUNT_W-1:0] > CAP_V) ? CAP_V :
                               csr_wdata[COUNT_W-1:0];
      stack_cmd.push_idx     = div_quotient;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               addr_in   = req_chan.addr;
               alloc_in  = '0;
               status_in = ST_OK;
               if (req_chan.req_type == REQ_ALLOC) begin
                  if (stack_top == '0) begin
                     status_in = ST_EXHAUSTED;
                     state_in  = S_DONE;
                  end else begin
                     stack_cmd.pop = 1'b1;
                     state_in      = S_POP;
                  end
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_POP: begin
            prod_in  = PROD_W'(pop_idx) * PROD_W'(size_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            alloc_in = (base_ff + ADDR_W'(prod_ff)) & ADDR_MASK;
            state_in = S_DONE;
         end
         S_CHECK: begin
            priority if (addr_ff == '0) begin
               status_in = ST_NULL;
               state_in  = S_DONE;
            end else if ((addr_ff < base_ff) || (offset >= ADDR_W'(span_ff))) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               priority if (!div_rem_zero) begin
                  status_in = ST_MISALIGNED;
               end else if (stack_top >= count_use) begin
                  status_in = ST_DOUBLE;
               end else begin
                  stack_cmd.push = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      alloc_ff  <= alloc_in;
      prod_ff   <= prod_in;
      status_ff <= status_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_alloc_ff  <= alloc_ff;
         rsp_count_ff  <= stack_top;
      end
   end

   assign req_chan.ready      = state_ff == S_IDLE;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.alloc_addr = rsp_alloc_ff;
   assign rsp_chan.free_count = rsp_count_ff;

   bfla_stack #(
      .MAX_BUFFERS (MAX_BUFFERS)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd     (stack_cmd),
      .top     (stack_top),
      .pop_idx (pop_idx)
   );

   bfla_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset[SPAN_W-1:0]),
      .divisor  (size_ff),
      .quotient (div_quotient),
      .rem_zero (div_rem_zero),
      .done     (div_done)
   );

endmodule

FILE: verif/buffer_free_list_allocator_tb.sv
// testbench of the buffer free-list allocator: directed pool cases, then random traffic
module buffer_free_list_allocator_tb;
   import bfla_pkg::*;

   localparam int POOL_DEPTH     = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  alloc_addr;
      logic [COUNT_W-1:0] free_count;
   } pool_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   bfla_req_if req_bus ();
   bfla_rsp_if rsp_bus ();

   buffer_free_list_allocator dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // pool predictor state
   logic [ADDR_W-1:0]  pool_base;
   logic [SIZE_W-1:0]  pool_size;
   logic [COUNT_W-1:0] pool_count;
   logic [COUNT_W-1:0] pool_top;
   logic [9:0]         pool_stack [POOL_DEPTH];

   pool_result_type   awaited_results [$];
   logic [ADDR_W-1:0] held_buffers [$];
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [COUNT_W-1:0] usable_count();
      return (pool_count > COUNT_W'(POOL_DEPTH)) ? COUNT_W'(POOL_DEPTH) : pool_count;
   endfunction

   // every entry back to its own index, all buffers in use are free
   function automatic void refill_pool_stack();
      for (int i = 0; i < POOL_DEPTH; i++) pool_stack[i] = 10'(i);
      pool_top = usable_count();
   endfunction

   function automatic void apply_pool_reg(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_W-1:0] value);
      case (index)
         CSR_BASE_ADDR: pool_base = value[ADDR_W-1:0];
         CSR_BUF_SIZE:  pool_size = value[SIZE_W-1:0];
         CSR_BUF_COUNT: begin
            pool_count = value[COUNT_W-1:0];
            refill_pool_stack();
         end
         default: ;
      endcase
   endfunction

   // expected outcome of one request, updating the free stack
   function automatic pool_result_type predict_pool_request(input logic kind,
                                                            input logic [ADDR_W-1:0] addr);
      pool_result_type    outcome;
      logic [63:0]        span;
      logic [ADDR_W-1:0]  offset;
      logic [9:0]         idx;
      logic [COUNT_W-1:0] usable;
      usable             = usable_count();
      outcome.status     = ST_OK;
      outcome.alloc_addr = '0;
      if (kind == REQ_ALLOC) begin
         if (pool_top == '0) begin
            outcome.status = ST_EXHAUSTED;
         end else begin
            pool_top           = pool_top - COUNT_W'(1);
            idx                = pool_stack[pool_top];
            outcome.alloc_addr = pool_base + ADDR_W'(idx) * ADDR_W'(pool_size);
         end
      end else begin
         span = 64'(usable) * 64'(pool_size);
         if (addr == '0) begin
            outcome.status = ST_NULL;
         end else if (addr < pool_base || 64'(addr - pool_base) >= span) begin
            outcome.status = ST_RANGE;
         end else begin
            offset = addr - pool_base;
            if (offset % ADDR_W'(pool_size) != '0) begin
               outcome.status = ST_MISALIGNED;
            end else if (pool_top >= usable) begin
               outcome.status = ST_DOUBLE;
            end else begin
               pool_stack[pool_top] = 10'(offset / ADDR_W'(pool_size));
               pool_top             = pool_top + COUNT_W'(1);
            end
         end
      end
      outcome.free_count = pool_top;
      return outcome;
   endfunction

   task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] expected,
                                  input logic [ADDR_W-1:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0h, got %0h", field, expected, actual);
   endtask

   // receiver stalls, changed at the falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result check against the oldest expectation
   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result status", '0, ADDR_W'(rsp_bus.status));
         end else begin
            want = awaited_results.pop_front();
            if (rsp_bus.status !== want.status)
               report_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp_bus.status));
            if (rsp_bus.alloc_addr !== want.alloc_addr)
               report_mismatch("alloc_addr", want.alloc_addr, rsp_bus.alloc_addr);
            if (rsp_bus.free_count !== want.free_count)
               report_mismatch("free_count", ADDR_W'(want.free_count),
                               ADDR_W'(rsp_bus.free_count));
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one request transfer, with random sender gaps beforehand
   task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
      pool_result_type outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.addr     <= addr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      outcome = predict_pool_request(kind, addr);
      awaited_results.push_back(outcome);
      if (kind == REQ_ALLOC && outcome.status == ST_OK)
         held_buffers.push_back(outcome.alloc_addr);
   endtask

   // stop requesting and wait for every expected result
   task automatic settle_pool();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_pool_reg(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      apply_pool_reg(index, value);
   endtask

   task automatic test_reset_defaults();
      send_request(REQ_ALLOC, 32'hFFFF_FFFF);
      send_request(REQ_FREE, ADDR_W'(1023 * 2048));
      send_request(REQ_FREE, '0);
      send_request(REQ_FREE, ADDR_W'(1024 * 2048));
      settle_pool();
   endtask

   // two-buffer pool: exhaustion, repeat free, full stack, null, range and misaligned rejections
   task automatic test_small_pool();
      write_pool_reg(CSR_BASE_ADDR, 32'h0000_1000);
      write_pool_reg(CSR_BUF_SIZE, 32'h0000_0100);
      write_pool_reg(CSR_BUF_COUNT, 32'd2);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_ALLOC, 32'h0000_1000);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 32'h0000_1000);
      send_request(REQ_FREE, 32'h0000_1000);
      send_request(REQ_FREE, 32'h0000_1100);
      send_request(REQ_FREE, 32'h0000_0FFF);
      send_request(REQ_FREE, 32'h0000_1200);
      send_request(REQ_FREE, 32'h0000_1080);
      send_request(REQ_FREE, '0);
      settle_pool();
   endtask

   // empty pool, then a pool of zero-byte buffers
   task automatic test_empty_pool();
      write_pool_reg(CSR_BUF_COUNT, 32'd0);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 32'h0000_1000);
      settle_pool();
      write_pool_reg(CSR_BUF_SIZE, 32'd0);
      write_pool_reg(CSR_BUF_COUNT, 32'd4);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 32'h0000_1000);
      settle_pool();
   endtask

   // count above the stack depth, largest size, top base so addresses wrap
   task automatic test_saturated_wrap();
      write_pool_reg(CSR_BASE_ADDR, 32'hFFFF_FFFF);
      write_pool_reg(CSR_BUF_SIZE, 32'h0000_FFFF);
      write_pool_reg(CSR_BUF_COUNT, 32'd2047);
      send_request(REQ_ALLOC, '0);
      send_request(REQ_FREE, 32'hFFFF_FFFF);
      send_request(REQ_FREE, 32'hFFFF_FFFE);
      send_request(REQ_ALLOC, '0);
      settle_pool();
   endtask

   task automatic configure_random_pool();
      logic [CSR_W-1:0] base_value, size_value, count_value;
      case ($urandom_range(4))
         0:       base_value = '0;
         1:       base_value = 32'hFFFF_FFFF;
         2:       base_value = $urandom;
         default: base_value = $urandom & 32'h00FF_F000;
      endcase
      if ($urandom_range(15) == 0) size_value = 0;
      else begin
         case ($urandom_range(4))
            0:       size_value = 1;
            1:       size_value = 32'h0000_FFFF;
            2:       size_value = $urandom_range(1, 65535);
            default: size_value = 1 << $urandom_range(0, 15);
         endcase
      end
      case ($urandom_range(11))
         0:       count_value = 0;
         1:       count_value = POOL_DEPTH;
         2:       count_value = 2047;
         3:       count_value = $urandom_range(1, POOL_DEPTH);
         default: count_value = $urandom_range(1, 16);
      endcase
      write_pool_reg(CSR_BASE_ADDR, base_value);
      write_pool_reg(CSR_BUF_SIZE, size_value);
      // sometimes leave the stack as it is
      if ($urandom_range(3) != 0) write_pool_reg(CSR_BUF_COUNT, count_value);
      held_buffers.delete();
   endtask

   // mostly allocate and free of held buffers, some malformed frees
   task automatic issue_random_item();
      logic [ADDR_W-1:0] addr, span;
      logic [COUNT_W-1:0] usable;
      int pick;
      int choice;
      usable = usable_count();
      span   = ADDR_W'(usable) * ADDR_W'(pool_size);
      choice = $urandom_range(99);
      if (choice < 45 || (choice < 80 && held_buffers.size() == 0)) begin
         send_request(REQ_ALLOC, $urandom);
      end else if (choice < 80) begin
         pick = $urandom_range(held_buffers.size() - 1);
         addr = held_buffers[pick];
         held_buffers.delete(pick);
         send_request(REQ_FREE, addr);
      end else begin
         case ($urandom_range(5))
            0: addr = '0;
            1: addr = $urandom;
            2: addr = pool_base +
                      ADDR_W'($urandom_range(0, (usable == 0) ? 0 : usable - 1)) *
                      ADDR_W'(pool_size);
            3: addr = pool_base + ADDR_W'($urandom_range(0, 15)) * ADDR_W'(pool_size) +
                      ((pool_size > 1) ? ADDR_W'($urandom_range(1, pool_size - 1)) : 1);
            4: addr = pool_base + span + ADDR_W'($urandom_range(0, 3)) * ADDR_W'(pool_size);
            default: addr = pool_base - 1 - ADDR_W'($urandom_range(0, 255));
         endcase
         send_request(REQ_FREE, addr);
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_total);
      int remaining;
      int run_length;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      remaining     = item_total;
      while (remaining > 0) begin
         settle_pool();
         configure_random_pool();
         run_length = $urandom_range(30, 80);
         if (run_length > remaining) run_length = remaining;
         repeat (run_length) issue_random_item();
         remaining -= run_length;
      end
      settle_pool();
   endtask

   // test sequence
   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = REQ_ALLOC;
      req_bus.addr     = '0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_BASE_ADDR;
      csr_wdata        = '0;
      pool_base        = BASE_RESET;
      pool_size        = SIZE_RESET;
      pool_count       = COUNT_RESET;
      refill_pool_stack();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_small_pool();
      test_empty_pool();
      test_saturated_wrap();
      test_random_traffic(16, 87, 360);
      test_random_traffic(87, 16, 360);
      test_random_traffic(0, 0, 360);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
